>>> rtl/core/bpdc_pkg.sv
// Shared types, widths and register codes for the buck PI duty controller.
package bpdc_pkg;

  // Field and datapath widths
  localparam int SAMPLE_BITS    = 12;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int CLAMP_BITS     = 12;
  localparam int STEP_MIN_BITS  = 13;
  localparam int TRIP_BITS      = 13;
  localparam int ERR_W          = SAMPLE_BITS + 1;
  localparam int ESUM_W         = ERR_W + 1;
  localparam int STEP_W         = GAIN_FRAC_BITS + 1 + ESUM_W;
  localparam int PROP_W         = GAIN_FRAC_BITS + 1 + ERR_W;
  localparam int INTEG_W        = 48;
  localparam int TOTAL_W        = INTEG_W + 1;

  // APB port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0]    SETPOINT_RST   = SAMPLE_BITS'(3031);
  localparam logic [GAIN_FRAC_BITS-1:0] PROP_GAIN_RST  = GAIN_FRAC_BITS'(1678);
  localparam logic [GAIN_FRAC_BITS-1:0] INT_GAIN_RST   = GAIN_FRAC_BITS'(923);
  localparam logic [CLAMP_BITS-1:0]     STEP_MAX_RST   = CLAMP_BITS'(1500);
  localparam logic [STEP_MIN_BITS-1:0]  STEP_MIN_RST   = '0;
  localparam logic [CLAMP_BITS-1:0]     OUT_MAX_RST    = CLAMP_BITS'(1500);
  localparam logic [CLAMP_BITS-1:0]     PERIOD_RST     = CLAMP_BITS'(1500);
  localparam logic [TRIP_BITS-1:0]      TRIP_LEVEL_RST = TRIP_BITS'(4096);

  // Register index codes
  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INT_GAIN   = 3'd2,
    REG_STEP_MAX   = 3'd3,
    REG_STEP_MIN   = 3'd4,
    REG_OUT_MAX    = 3'd5,
    REG_PERIOD     = 3'd6,
    REG_TRIP_LEVEL = 3'd7
  } reg_idx_t;

  // Input word
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   run;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [CLAMP_BITS-1:0] compare;
    logic [CLAMP_BITS-1:0] drive;
    logic                  trip;
  } out_word_t;

  // Configuration bundle from the register block
  typedef struct packed {
    logic [SAMPLE_BITS-1:0]    setpoint;
    logic [GAIN_FRAC_BITS-1:0] prop_gain;
    logic [GAIN_FRAC_BITS-1:0] int_gain;
    logic [CLAMP_BITS-1:0]     step_max;
    logic [STEP_MIN_BITS-1:0]  step_min;
    logic [CLAMP_BITS-1:0]     out_max;
    logic [CLAMP_BITS-1:0]     period;
    logic [TRIP_BITS-1:0]      trip_level;
  } cfg_t;

endpackage

>>> rtl/core/buck_pi_duty_controller.sv
// Top level of the buck PI duty controller: four-stage PI datapath and APB registers.
//
//   channel  direction  handshake             word
//   in       input      in_valid / in_stall   in_data  (sample, run)
//   out      output     out_valid / out_stall out_data (compare, drive, trip)
//   cfg      input      APB psel/penable      paddr, pwdata, prdata
//
// One word is taken every cycle while in_stall is low; a run word passes through the
// input register, multiply stage, integrator stage and result register to give its result.
// Sustained rate is one word per cycle while out is not stalled, as the integrator updates once per word.
// Words with run low are taken and dropped. rst is synchronous and empties all stages.
// A stall on out holds the result register; the stages behind it fill, then in_stall rises.
module buck_pi_duty_controller (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bpdc_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bpdc_pkg::out_word_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpdc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpdc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int SB  = bpdc_pkg::SAMPLE_BITS;
  localparam int GF  = bpdc_pkg::GAIN_FRAC_BITS;
  localparam int EW  = bpdc_pkg::ERR_W;
  localparam int SW  = bpdc_pkg::ESUM_W;
  localparam int STW = bpdc_pkg::STEP_W;
  localparam int PW  = bpdc_pkg::PROP_W;
  localparam int IW  = bpdc_pkg::INTEG_W;
  localparam int TW  = bpdc_pkg::TOTAL_W;
  localparam int CB  = bpdc_pkg::CLAMP_BITS;
  localparam int MB  = bpdc_pkg::STEP_MIN_BITS;

  localparam logic signed [IW-1:0] INTEG_MAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN = {1'b1, {(IW-1){1'b0}}};

  bpdc_pkg::cfg_t cfg;

  bpdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage registers
  logic                    a_valid, b_valid, c_valid, d_valid;
  logic [SB-1:0]           a_sample;
  logic signed [STW-1:0]   b_step;
  logic signed [PW-1:0]    b_prop;
  logic                    b_trip;
  logic signed [PW-1:0]    c_prop;
  logic                    c_trip;
  logic signed [EW-1:0]    prev_error;
  logic signed [IW-1:0]    integ;

  // Flow control: each stage frees up when empty or when it moves on
  logic d_free, c_free, b_free, a_free;
  logic b_ld, c_ld, d_ld, a_ld;

  assign d_free   = !d_valid || !out_stall;
  assign c_free   = !c_valid || d_free;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign d_ld     = c_valid && d_free;
  assign c_ld     = b_valid && c_free;
  assign b_ld     = a_valid && b_free;
  assign a_ld     = in_valid && a_free && in_data.run;
  assign in_stall = !a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= in_valid && in_data.run;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid;
      if (d_free) d_valid <= c_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (a_ld) a_sample <= in_data.sample;
  end

  // Error, error sum and both gain products
  logic signed [EW-1:0]  err;
  logic signed [SW-1:0]  esum;
  logic signed [STW-1:0] step_prod;
  logic signed [PW-1:0]  prop_prod;
  logic                  trip_b;

  always_comb begin
    err       = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, a_sample});
    esum      = $signed({err[EW-1], err}) + $signed({prev_error[EW-1], prev_error});
    step_prod = $signed({1'b0, cfg.int_gain}) * esum;
    prop_prod = $signed({1'b0, cfg.prop_gain}) * err;
    trip_b    = {1'b0, a_sample} > cfg.trip_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
    end else if (b_ld) begin
      prev_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ld) begin
      b_step <= step_prod;
      b_prop <= prop_prod;
      b_trip <= trip_b;
    end
  end

  // Step clamp (upper bound first) and saturating integrator
  logic signed [STW-1:0] step_hi, step_lo, step_c;
  logic signed [IW:0]    acc;
  logic signed [IW-1:0]  integ_next;

  always_comb begin
    step_hi = $signed({{(STW-CB-GF){1'b0}}, cfg.step_max, {GF{1'b0}}});
    step_lo = $signed({{(STW-MB-GF){cfg.step_min[MB-1]}}, cfg.step_min, {GF{1'b0}}});
    if (b_step >= step_hi) begin
      step_c = step_hi;
    end else if (b_step <= step_lo) begin
      step_c = step_lo;
    end else begin
      step_c = b_step;
    end
    acc = $signed({integ[IW-1], integ}) + $signed({{(IW+1-STW){step_c[STW-1]}}, step_c});
    if (acc[IW] != acc[IW-1]) begin
      integ_next = acc[IW] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_next = acc[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (c_ld) begin
      integ <= integ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ld) begin
      c_prop <= b_prop;
      c_trip <= b_trip;
    end
  end

  // Drive: integer part, clamped to [0, out_max]; compare floors at zero
  logic signed [TW-1:0] total;
  logic [IW-GF-1:0]     whole;
  logic [CB-1:0]        drive_d;
  logic [CB-1:0]        compare_d;

  always_comb begin
    total = $signed({integ[IW-1], integ}) + $signed({{(TW-PW){c_prop[PW-1]}}, c_prop});
    whole = total[IW-1:GF];
    if (total[TW-1]) begin
      drive_d = '0;
    end else if (whole >= (IW-GF)'(cfg.out_max)) begin
      drive_d = cfg.out_max;
    end else begin
      drive_d = whole[CB-1:0];
    end
    compare_d = (drive_d > cfg.period) ? '0 : cfg.period - drive_d;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (d_ld) begin
      out_data.compare <= compare_d;
      out_data.drive   <= drive_d;
      out_data.trip    <= c_trip;
    end
  end

  assign out_valid = d_valid;

`ifndef SYNTHESIS
  // Drive never exceeds its clamp while a result is shown
  a_drive_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.drive <= cfg.out_max)
    else $error("drive above out_max");

  // Compare is period minus drive when drive fits under period
  a_compare: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.drive <= cfg.period) |->
      out_data.compare == cfg.period - out_data.drive)
    else $error("compare does not match period minus drive");

  // Integrator only moves when a word enters the integrator stage
  a_integ_hold: assert property (@(posedge clk) disable iff (rst)
    !c_ld |=> $stable(integ))
    else $error("integrator changed without a word");

  // The input side is only held back when every stage is full and out is stalled
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> a_valid && b_valid && c_valid && d_valid && out_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> rtl/core/bpdc_regs.sv
// APB configuration registers of the buck PI duty controller.
module bpdc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpdc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpdc_pkg::DATA_W-1:0]  pwdata,
  output logic [bpdc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bpdc_pkg::cfg_t               cfg
);

  bpdc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = bpdc_pkg::reg_idx_t'(paddr[bpdc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint   <= bpdc_pkg::SETPOINT_RST;
      cfg.prop_gain  <= bpdc_pkg::PROP_GAIN_RST;
      cfg.int_gain   <= bpdc_pkg::INT_GAIN_RST;
      cfg.step_max   <= bpdc_pkg::STEP_MAX_RST;
      cfg.step_min   <= bpdc_pkg::STEP_MIN_RST;
      cfg.out_max    <= bpdc_pkg::OUT_MAX_RST;
      cfg.period     <= bpdc_pkg::PERIOD_RST;
      cfg.trip_level <= bpdc_pkg::TRIP_LEVEL_RST;
    end else if (wr_en) begin
      unique case (idx)
        bpdc_pkg::REG_SETPOINT:   cfg.setpoint   <= pwdata[bpdc_pkg::SAMPLE_BITS-1:0];
        bpdc_pkg::REG_PROP_GAIN:  cfg.prop_gain  <= pwdata[bpdc_pkg::GAIN_FRAC_BITS-1:0];
        bpdc_pkg::REG_INT_GAIN:   cfg.int_gain   <= pwdata[bpdc_pkg::GAIN_FRAC_BITS-1:0];
        bpdc_pkg::REG_STEP_MAX:   cfg.step_max   <= pwdata[bpdc_pkg::CLAMP_BITS-1:0];
        bpdc_pkg::REG_STEP_MIN:   cfg.step_min   <= pwdata[bpdc_pkg::STEP_MIN_BITS-1:0];
        bpdc_pkg::REG_OUT_MAX:    cfg.out_max    <= pwdata[bpdc_pkg::CLAMP_BITS-1:0];
        bpdc_pkg::REG_PERIOD:     cfg.period     <= pwdata[bpdc_pkg::CLAMP_BITS-1:0];
        bpdc_pkg::REG_TRIP_LEVEL: cfg.trip_level <= pwdata[bpdc_pkg::TRIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back; step_min is sign extended
  always_comb begin
    unique case (idx)
      bpdc_pkg::REG_SETPOINT:   prdata = bpdc_pkg::DATA_W'(cfg.setpoint);
      bpdc_pkg::REG_PROP_GAIN:  prdata = bpdc_pkg::DATA_W'(cfg.prop_gain);
      bpdc_pkg::REG_INT_GAIN:   prdata = bpdc_pkg::DATA_W'(cfg.int_gain);
      bpdc_pkg::REG_STEP_MAX:   prdata = bpdc_pkg::DATA_W'(cfg.step_max);
      bpdc_pkg::REG_STEP_MIN:   prdata = bpdc_pkg::DATA_W'($signed(cfg.step_min));
      bpdc_pkg::REG_OUT_MAX:    prdata = bpdc_pkg::DATA_W'(cfg.out_max);
      bpdc_pkg::REG_PERIOD:     prdata = bpdc_pkg::DATA_W'(cfg.period);
      bpdc_pkg::REG_TRIP_LEVEL: prdata = bpdc_pkg::DATA_W'(cfg.trip_level);
      default:                  prdata = '0;
    endcase
  end

endmodule
